FILE: hw/rtl/kft_pkg.sv
`default_nettype none
package kft_pkg;

  // Data format: signed Q16.16 words
  localparam int DW = 32;
  localparam int FB = 16;
  // Magnitude width of a rounded product or a quotient before saturation
  localparam int QW = DW + FB;
  localparam int CFW = 31;
  localparam int NCFG = 6;
  localparam int CIW = 3;
  localparam int KW = 3;
  localparam int NOUT = 12;
  localparam int CW = $clog2(NOUT + 1);
  localparam int SW = 7;
  localparam int RDEPTH = 42;
  localparam int AW = $clog2(RDEPTH);

  localparam logic [CFW-1:0] CFG_RST = CFW'(65536);
  localparam logic [DW-1:0] Q_ONE = DW'(1) << FB;

  // Item kinds
  localparam logic [KW-1:0] K_RESET = 3'd0;
  localparam logic [KW-1:0] K_PRED  = 3'd1;
  localparam logic [KW-1:0] K_PUPD  = 3'd2;
  localparam logic [KW-1:0] K_FUPD  = 3'd3;
  localparam logic [KW-1:0] K_JOINT = 3'd4;

  // Configuration register indexes
  localparam logic [CIW-1:0] CFG_VP = 3'd0;
  localparam logic [CIW-1:0] CFG_VF = 3'd1;
  localparam logic [CIW-1:0] CFG_QP = 3'd2;
  localparam logic [CIW-1:0] CFG_QF = 3'd3;
  localparam logic [CIW-1:0] CFG_RP = 3'd4;
  localparam logic [CIW-1:0] CFG_RF = 3'd5;

  // Micro-op codes
  localparam logic [3:0] OP_END = 4'd0;
  localparam logic [3:0] OP_LD  = 4'd1;
  localparam logic [3:0] OP_MOV = 4'd2;
  localparam logic [3:0] OP_ADD = 4'd3;
  localparam logic [3:0] OP_SUB = 4'd4;
  localparam logic [3:0] OP_NEG = 4'd5;
  localparam logic [3:0] OP_MUL = 4'd6;
  localparam logic [3:0] OP_DIV = 4'd7;
  localparam logic [3:0] OP_BZ  = 4'd8;

  // Load sources
  localparam logic [3:0] SRC_ZP   = 4'd0;
  localparam logic [3:0] SRC_ZF   = 4'd1;
  localparam logic [3:0] SRC_IP   = 4'd2;
  localparam logic [3:0] SRC_IF   = 4'd3;
  localparam logic [3:0] SRC_VP   = 4'd4;
  localparam logic [3:0] SRC_VF   = 4'd5;
  localparam logic [3:0] SRC_QP   = 4'd6;
  localparam logic [3:0] SRC_QF   = 4'd7;
  localparam logic [3:0] SRC_RP   = 4'd8;
  localparam logic [3:0] SRC_RF   = 4'd9;
  localparam logic [3:0] SRC_ONE  = 4'd10;
  localparam logic [3:0] SRC_ZERO = 4'd11;

  // Write-back select
  localparam logic [1:0] WS_ALU = 2'd0;
  localparam logic [1:0] WS_MUL = 2'd1;
  localparam logic [1:0] WS_DIV = 2'd2;

  // Register file map: reported state first, in output order
  localparam logic [AW-1:0] A_PH  = 6'd0;
  localparam logic [AW-1:0] A_FR  = 6'd1;
  localparam logic [AW-1:0] A_P00 = 6'd2;
  localparam logic [AW-1:0] A_P01 = 6'd3;
  localparam logic [AW-1:0] A_P10 = 6'd4;
  localparam logic [AW-1:0] A_P11 = 6'd5;
  localparam logic [AW-1:0] A_IN0 = 6'd6;
  localparam logic [AW-1:0] A_IN1 = 6'd7;
  localparam logic [AW-1:0] A_G00 = 6'd8;
  localparam logic [AW-1:0] A_G01 = 6'd9;
  localparam logic [AW-1:0] A_G10 = 6'd10;
  localparam logic [AW-1:0] A_G11 = 6'd11;
  localparam logic [AW-1:0] A_ZP  = 6'd12;
  localparam logic [AW-1:0] A_ZF  = 6'd13;
  localparam logic [AW-1:0] A_RP  = 6'd14;
  localparam logic [AW-1:0] A_RF  = 6'd15;
  localparam logic [AW-1:0] A_QP  = 6'd16;
  localparam logic [AW-1:0] A_QF  = 6'd17;
  localparam logic [AW-1:0] A_ONE = 6'd18;
  localparam logic [AW-1:0] A_YP  = 6'd19;
  localparam logic [AW-1:0] A_YF  = 6'd20;
  localparam logic [AW-1:0] A_S0  = 6'd21;
  localparam logic [AW-1:0] A_S1  = 6'd22;
  localparam logic [AW-1:0] A_T1  = 6'd23;
  localparam logic [AW-1:0] A_T2  = 6'd24;
  localparam logic [AW-1:0] A_DET = 6'd25;
  localparam logic [AW-1:0] A_I00 = 6'd26;
  localparam logic [AW-1:0] A_I01 = 6'd27;
  localparam logic [AW-1:0] A_I10 = 6'd28;
  localparam logic [AW-1:0] A_I11 = 6'd29;
  localparam logic [AW-1:0] A_K00 = 6'd30;
  localparam logic [AW-1:0] A_K01 = 6'd31;
  localparam logic [AW-1:0] A_K10 = 6'd32;
  localparam logic [AW-1:0] A_K11 = 6'd33;
  localparam logic [AW-1:0] A_A00 = 6'd34;
  localparam logic [AW-1:0] A_A01 = 6'd35;
  localparam logic [AW-1:0] A_A10 = 6'd36;
  localparam logic [AW-1:0] A_A11 = 6'd37;
  localparam logic [AW-1:0] A_N00 = 6'd38;
  localparam logic [AW-1:0] A_N01 = 6'd39;
  localparam logic [AW-1:0] A_N10 = 6'd40;
  localparam logic [AW-1:0] A_N11 = 6'd41;

  typedef struct packed {
    logic [3:0]    op;
    logic [3:0]    src;
    logic [AW-1:0] a;
    logic [AW-1:0] b;
    logic [AW-1:0] d;
  } uop_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic [AW-1:0] ra;
    logic [AW-1:0] rb;
    logic [AW-1:0] wa;
    logic          we;
    logic [1:0]    wsel;
    logic [3:0]    op;
    logic [3:0]    src;
    logic          mul_go;
    logic          div_go;
    logic          in_load;
    logic          cap_en;
    logic [CW-1:0] cap_idx;
    logic          out_set;
  } cmd_t;

  // Status from the datapath
  typedef struct packed {
    logic a_zero;
    logic div_done;
    logic out_busy;
  } stat_t;

  // Saturate a one-bit-grown sum to the word range
  function automatic logic [DW-1:0] sat_w(input logic [DW:0] s);
    logic [DW-1:0] r;
    if (s[DW] != s[DW-1]) begin
      r = s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      r = s[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    return sat_w(s);
  endfunction

  function automatic logic [DW-1:0] sat_sub(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    return sat_w(s);
  endfunction

  // Apply a sign to a magnitude and saturate
  function automatic logic [DW-1:0] sat_mag(input logic [QW-1:0] m, input logic neg);
    logic [QW-1:0] lim;
    logic [DW-1:0] r;
    lim = QW'(1) << (DW - 1);
    if (neg) begin
      r = (m > lim) ? {1'b1, {(DW-1){1'b0}}} : DW'(QW'(0) - m);
    end else begin
      r = (m >= lim) ? {1'b0, {(DW-1){1'b1}}} : m[DW-1:0];
    end
    return r;
  endfunction

  function automatic uop_t mk(input logic [3:0] op, input logic [AW-1:0] a,
                              input logic [AW-1:0] b, input logic [AW-1:0] d);
    uop_t u;
    u.op = op;
    u.src = SRC_ZERO;
    u.a = a;
    u.b = b;
    u.d = d;
    return u;
  endfunction

  function automatic uop_t ld(input logic [3:0] src, input logic [AW-1:0] d);
    uop_t u;
    u.op = OP_LD;
    u.src = src;
    u.a = A_PH;
    u.b = A_PH;
    u.d = d;
    return u;
  endfunction

  // Micro-program for each kind, one operation per step
  function automatic uop_t ucode(input logic [KW-1:0] kind, input logic [SW-1:0] step);
    uop_t u;
    u = mk(OP_END, A_PH, A_PH, A_PH);
    case (kind)
      K_RESET: begin
        case (step)
          7'd0:  u = ld(SRC_IP, A_PH);
          7'd1:  u = ld(SRC_IF, A_FR);
          7'd2:  u = ld(SRC_VP, A_P00);
          7'd3:  u = ld(SRC_ZERO, A_P01);
          7'd4:  u = ld(SRC_ZERO, A_P10);
          7'd5:  u = ld(SRC_VF, A_P11);
          7'd6:  u = ld(SRC_ZERO, A_IN0);
          7'd7:  u = ld(SRC_ZERO, A_IN1);
          7'd8:  u = ld(SRC_ZERO, A_G00);
          7'd9:  u = ld(SRC_ZERO, A_G01);
          7'd10: u = ld(SRC_ZERO, A_G10);
          7'd11: u = ld(SRC_ZERO, A_G11);
          default: u = mk(OP_END, A_PH, A_PH, A_PH);
        endcase
      end
      K_PRED: begin
        case (step)
          7'd0: u = ld(SRC_QP, A_QP);
          7'd1: u = ld(SRC_QF, A_QF);
          7'd2: u = mk(OP_ADD, A_PH, A_FR, A_PH);
          7'd3: u = mk(OP_ADD, A_P00, A_P01, A_T1);
          7'd4: u = mk(OP_ADD, A_T1, A_P10, A_T1);
          7'd5: u = mk(OP_ADD, A_T1, A_P11, A_T1);
          7'd6: u = mk(OP_ADD, A_T1, A_QP, A_P00);
          7'd7: u = mk(OP_ADD, A_P01, A_P11, A_P01);
          7'd8: u = mk(OP_ADD, A_P10, A_P11, A_P10);
          7'd9: u = mk(OP_ADD, A_P11, A_QF, A_P11);
          default: u = mk(OP_END, A_PH, A_PH, A_PH);
        endcase
      end
      K_PUPD: begin
        case (step)
          7'd0:  u = ld(SRC_ZP, A_ZP);
          7'd1:  u = ld(SRC_RP, A_RP);
          7'd2:  u = mk(OP_SUB, A_ZP, A_PH, A_YP);
          7'd3:  u = mk(OP_ADD, A_P00, A_RP, A_S0);
          7'd4:  u = mk(OP_BZ, A_S0, A_S0, A_S0);
          7'd5:  u = mk(OP_DIV, A_P00, A_S0, A_K00);
          7'd6:  u = mk(OP_DIV, A_P10, A_S0, A_K10);
          7'd7:  u = mk(OP_MUL, A_K00, A_YP, A_T1);
          7'd8:  u = mk(OP_ADD, A_PH, A_T1, A_PH);
          7'd9:  u = mk(OP_MUL, A_K10, A_YP, A_T1);
          7'd10: u = mk(OP_ADD, A_FR, A_T1, A_FR);
          7'd11: u = ld(SRC_ONE, A_ONE);
          7'd12: u = mk(OP_SUB, A_ONE, A_K00, A_A00);
          7'd13: u = mk(OP_MUL, A_K10, A_P00, A_T1);
          7'd14: u = mk(OP_SUB, A_P10, A_T1, A_P10);
          7'd15: u = mk(OP_MUL, A_K10, A_P01, A_T1);
          7'd16: u = mk(OP_SUB, A_P11, A_T1, A_P11);
          7'd17: u = mk(OP_MUL, A_A00, A_P00, A_P00);
          7'd18: u = mk(OP_MUL, A_A00, A_P01, A_P01);
          7'd19: u = mk(OP_MOV, A_YP, A_YP, A_IN0);
          7'd20: u = ld(SRC_ZERO, A_IN1);
          7'd21: u = mk(OP_MOV, A_K00, A_K00, A_G00);
          7'd22: u = ld(SRC_ZERO, A_G01);
          7'd23: u = mk(OP_MOV, A_K10, A_K10, A_G10);
          7'd24: u = ld(SRC_ZERO, A_G11);
          default: u = mk(OP_END, A_PH, A_PH, A_PH);
        endcase
      end
      K_FUPD: begin
        case (step)
          7'd0:  u = ld(SRC_ZF, A_ZF);
          7'd1:  u = ld(SRC_RF, A_RF);
          7'd2:  u = mk(OP_SUB, A_ZF, A_FR, A_YP);
          7'd3:  u = mk(OP_ADD, A_P11, A_RF, A_S0);
          7'd4:  u = mk(OP_BZ, A_S0, A_S0, A_S0);
          7'd5:  u = mk(OP_DIV, A_P01, A_S0, A_K00);
          7'd6:  u = mk(OP_DIV, A_P11, A_S0, A_K10);
          7'd7:  u = mk(OP_MUL, A_K00, A_YP, A_T1);
          7'd8:  u = mk(OP_ADD, A_PH, A_T1, A_PH);
          7'd9:  u = mk(OP_MUL, A_K10, A_YP, A_T1);
          7'd10: u = mk(OP_ADD, A_FR, A_T1, A_FR);
          7'd11: u = ld(SRC_ONE, A_ONE);
          7'd12: u = mk(OP_SUB, A_ONE, A_K10, A_A00);
          7'd13: u = mk(OP_MUL, A_K00, A_P10, A_T1);
          7'd14: u = mk(OP_SUB, A_P00, A_T1, A_P00);
          7'd15: u = mk(OP_MUL, A_K00, A_P11, A_T1);
          7'd16: u = mk(OP_SUB, A_P01, A_T1, A_P01);
          7'd17: u = mk(OP_MUL, A_A00, A_P10, A_P10);
          7'd18: u = mk(OP_MUL, A_A00, A_P11, A_P11);
          7'd19: u = mk(OP_MOV, A_YP, A_YP, A_IN0);
          7'd20: u = ld(SRC_ZERO, A_IN1);
          7'd21: u = mk(OP_MOV, A_K00, A_K00, A_G00);
          7'd22: u = ld(SRC_ZERO, A_G01);
          7'd23: u = mk(OP_MOV, A_K10, A_K10, A_G10);
          7'd24: u = ld(SRC_ZERO, A_G11);
          default: u = mk(OP_END, A_PH, A_PH, A_PH);
        endcase
      end
      K_JOINT: begin
        case (step)
          7'd0:  u = ld(SRC_ZP, A_ZP);
          7'd1:  u = ld(SRC_ZF, A_ZF);
          7'd2:  u = ld(SRC_RP, A_RP);
          7'd3:  u = ld(SRC_RF, A_RF);
          7'd4:  u = mk(OP_SUB, A_ZP, A_PH, A_YP);
          7'd5:  u = mk(OP_SUB, A_ZF, A_FR, A_YF);
          7'd6:  u = mk(OP_ADD, A_P00, A_RP, A_S0);
          7'd7:  u = mk(OP_ADD, A_P11, A_RF, A_S1);
          7'd8:  u = mk(OP_MUL, A_S0, A_S1, A_T1);
          7'd9:  u = mk(OP_MUL, A_P01, A_P10, A_T2);
          7'd10: u = mk(OP_SUB, A_T1, A_T2, A_DET);
          7'd11: u = mk(OP_BZ, A_DET, A_DET, A_DET);
          7'd12: u = mk(OP_DIV, A_S1, A_DET, A_I00);
          7'd13: u = mk(OP_NEG, A_P01, A_P01, A_T1);
          7'd14: u = mk(OP_DIV, A_T1, A_DET, A_I01);
          7'd15: u = mk(OP_NEG, A_P10, A_P10, A_T1);
          7'd16: u = mk(OP_DIV, A_T1, A_DET, A_I10);
          7'd17: u = mk(OP_DIV, A_S0, A_DET, A_I11);
          7'd18: u = mk(OP_MUL, A_P00, A_I00, A_T1);
          7'd19: u = mk(OP_MUL, A_P01, A_I10, A_T2);
          7'd20: u = mk(OP_ADD, A_T1, A_T2, A_K00);
          7'd21: u = mk(OP_MUL, A_P00, A_I01, A_T1);
          7'd22: u = mk(OP_MUL, A_P01, A_I11, A_T2);
          7'd23: u = mk(OP_ADD, A_T1, A_T2, A_K01);
          7'd24: u = mk(OP_MUL, A_P10, A_I00, A_T1);
          7'd25: u = mk(OP_MUL, A_P11, A_I10, A_T2);
          7'd26: u = mk(OP_ADD, A_T1, A_T2, A_K10);
          7'd27: u = mk(OP_MUL, A_P10, A_I01, A_T1);
          7'd28: u = mk(OP_MUL, A_P11, A_I11, A_T2);
          7'd29: u = mk(OP_ADD, A_T1, A_T2, A_K11);
          7'd30: u = mk(OP_MUL, A_K00, A_YP, A_T1);
          7'd31: u = mk(OP_ADD, A_PH, A_T1, A_PH);
          7'd32: u = mk(OP_MUL, A_K01, A_YF, A_T1);
          7'd33: u = mk(OP_ADD, A_PH, A_T1, A_PH);
          7'd34: u = mk(OP_MUL, A_K10, A_YP, A_T1);
          7'd35: u = mk(OP_ADD, A_FR, A_T1, A_FR);
          7'd36: u = mk(OP_MUL, A_K11, A_YF, A_T1);
          7'd37: u = mk(OP_ADD, A_FR, A_T1, A_FR);
          7'd38: u = ld(SRC_ONE, A_ONE);
          7'd39: u = mk(OP_SUB, A_ONE, A_K00, A_A00);
          7'd40: u = mk(OP_NEG, A_K01, A_K01, A_A01);
          7'd41: u = mk(OP_NEG, A_K10, A_K10, A_A10);
          7'd42: u = mk(OP_SUB, A_ONE, A_K11, A_A11);
          7'd43: u = mk(OP_MUL, A_A00, A_P00, A_T1);
          7'd44: u = mk(OP_MUL, A_A01, A_P10, A_T2);
          7'd45: u = mk(OP_ADD, A_T1, A_T2, A_N00);
          7'd46: u = mk(OP_MUL, A_A00, A_P01, A_T1);
          7'd47: u = mk(OP_MUL, A_A01, A_P11, A_T2);
          7'd48: u = mk(OP_ADD, A_T1, A_T2, A_N01);
          7'd49: u = mk(OP_MUL, A_A10, A_P00, A_T1);
          7'd50: u = mk(OP_MUL, A_A11, A_P10, A_T2);
          7'd51: u = mk(OP_ADD, A_T1, A_T2, A_N10);
          7'd52: u = mk(OP_MUL, A_A10, A_P01, A_T1);
          7'd53: u = mk(OP_MUL, A_A11, A_P11, A_T2);
          7'd54: u = mk(OP_ADD, A_T1, A_T2, A_N11);
          7'd55: u = mk(OP_MOV, A_N00, A_N00, A_P00);
          7'd56: u = mk(OP_MOV, A_N01, A_N01, A_P01);
          7'd57: u = mk(OP_MOV, A_N10, A_N10, A_P10);
          7'd58: u = mk(OP_MOV, A_N11, A_N11, A_P11);
          7'd59: u = mk(OP_MOV, A_YP, A_YP, A_IN0);
          7'd60: u = mk(OP_MOV, A_YF, A_YF, A_IN1);
          7'd61: u = mk(OP_MOV, A_K00, A_K00, A_G00);
          7'd62: u = mk(OP_MOV, A_K01, A_K01, A_G01);
          7'd63: u = mk(OP_MOV, A_K10, A_K10, A_G10);
          7'd64: u = mk(OP_MOV, A_K11, A_K11, A_G11);
          default: u = mk(OP_END, A_PH, A_PH, A_PH);
        endcase
      end
      default: u = mk(OP_END, A_PH, A_PH, A_PH);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/phase_freq_kalman_tracker_core.sv
// Two-state phase/frequency Kalman tracker in saturating Q16.16. Each request
// (kind in in_tuser) runs a micro-program on one shared ALU, a 32x32 multiplier
// with a rounding stage, and a one-bit-per-cycle divider, so requests are
// handled one at a time. Each micro-op is fetched and then executed; a
// multiply then writes back its rounded product and a divide waits for the
// divider. A final fetch ends the program and the state is copied into the
// result buffer; a skipped update goes straight to the copy. The next request
// is taken in the idle state. After reset the block loads its initial state
// before it takes the first request. A finished result waits in its own
// buffer while the next request is taken.
`default_nettype none
module phase_freq_kalman_tracker_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // meas_phase, meas_freq, init_phase, init_freq
  input  wire logic [4*kft_pkg::DW-1:0]            in_tdata,
  // kind
  input  wire logic [kft_pkg::KW-1:0]              in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // est_phase, est_freq, cov_00, cov_01, cov_10, cov_11, innov_phase,
  // innov_freq, gain_00, gain_01, gain_10, gain_11
  output logic [kft_pkg::NOUT*kft_pkg::DW-1:0]     out_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [kft_pkg::CIW-1:0]             cfg_index,
  input  wire logic [kft_pkg::CFW-1:0]             cfg_data
);

  kft_pkg::cmd_t  cmd;
  kft_pkg::stat_t st;

  assign cfg_ready = 1'b1;

  kft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .st        (st)
  );

  kft_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/kft_ram.sv
`default_nettype none
module kft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/kft_div.sv
`default_nettype none
module kft_div (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [kft_pkg::DW-1:0] num,
  input  wire logic [kft_pkg::DW-1:0] den,
  output logic                        busy,
  output logic                        done,
  output logic      [kft_pkg::DW-1:0] quo
);

  localparam int CNW = $clog2(kft_pkg::QW);

  logic [kft_pkg::DW-1:0] mag_n;
  logic [kft_pkg::DW-1:0] mag_d;
  logic [kft_pkg::QW-1:0] dividend;
  logic [kft_pkg::QW-1:0] acc_r;
  logic [kft_pkg::DW-1:0] rem_r;
  logic [kft_pkg::DW-1:0] den_r;
  logic [kft_pkg::DW:0]   shifted;
  logic                   fits;
  logic [CNW-1:0]         cnt_r;
  logic                   neg_r;
  logic                   busy_r;
  logic                   done_r;

  // Magnitudes and the rounded dividend (|a| << frac) + |b| / 2
  always_comb begin
    mag_n = num[kft_pkg::DW-1] ? kft_pkg::DW'(-num) : num;
    mag_d = den[kft_pkg::DW-1] ? kft_pkg::DW'(-den) : den;
    dividend = {mag_n, {kft_pkg::FB{1'b0}}} + kft_pkg::QW'(mag_d >> 1);
    shifted = {rem_r, acc_r[kft_pkg::QW-1]};
    fits = shifted >= {1'b0, den_r};
  end

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNW'(kft_pkg::QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= dividend;
      rem_r <= '0;
      den_r <= mag_d;
      neg_r <= num[kft_pkg::DW-1] ^ den[kft_pkg::DW-1];
    end else if (busy_r) begin
      acc_r <= {acc_r[kft_pkg::QW-2:0], fits};
      rem_r <= fits ? kft_pkg::DW'(shifted - {1'b0, den_r}) : shifted[kft_pkg::DW-1:0];
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo = kft_pkg::sat_mag(acc_r, neg_r);

endmodule
`default_nettype wire

FILE: hw/rtl/kft_dp.sv
`default_nettype none
module kft_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [kft_pkg::CIW-1:0]           cfg_index,
  input  wire logic [kft_pkg::CFW-1:0]           cfg_data,
  input  wire logic [4*kft_pkg::DW-1:0]          in_tdata,
  input  wire kft_pkg::cmd_t                     cmd,
  output kft_pkg::stat_t                         st,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [kft_pkg::NOUT*kft_pkg::DW-1:0]   out_tdata
);

  logic [kft_pkg::CFW-1:0]     cfg_r [kft_pkg::NCFG];
  logic [kft_pkg::DW-1:0]      inp_r [4];
  logic [kft_pkg::DW-1:0]      out_r [kft_pkg::NOUT];
  logic                        out_valid_r;
  logic [kft_pkg::DW-1:0]      opa;
  logic [kft_pkg::DW-1:0]      opb;
  logic [kft_pkg::DW-1:0]      src_val;
  logic [kft_pkg::DW-1:0]      alu_q;
  logic [kft_pkg::DW-1:0]      mul_q;
  logic [kft_pkg::DW-1:0]      div_q;
  logic [kft_pkg::DW-1:0]      wdata;
  logic signed [2*kft_pkg::DW-1:0] prod_r;
  logic [2*kft_pkg::DW-1:0]    prod_mag;
  logic [2*kft_pkg::DW-1:0]    prod_rnd;
  logic                        div_busy;
  logic                        div_done;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < kft_pkg::NCFG; i++) begin
        cfg_r[i] <= kft_pkg::CFG_RST;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        kft_pkg::CFG_VP: cfg_r[0] <= cfg_data;
        kft_pkg::CFG_VF: cfg_r[1] <= cfg_data;
        kft_pkg::CFG_QP: cfg_r[2] <= cfg_data;
        kft_pkg::CFG_QF: cfg_r[3] <= cfg_data;
        kft_pkg::CFG_RP: cfg_r[4] <= cfg_data;
        kft_pkg::CFG_RF: cfg_r[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the request fields; zero after reset for the power-on load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        inp_r[i] <= '0;
      end
    end else if (cmd.in_load) begin
      for (int i = 0; i < 4; i++) begin
        inp_r[i] <= in_tdata[i*kft_pkg::DW +: kft_pkg::DW];
      end
    end
  end

  kft_ram #(
    .WIDTH(kft_pkg::DW),
    .DEPTH(kft_pkg::RDEPTH)
  ) u_rf (
    .clk     (clk),
    .we      (cmd.we),
    .waddr   (cmd.wa),
    .wdata   (wdata),
    .raddr_a (cmd.ra),
    .raddr_b (cmd.rb),
    .rdata_a (opa),
    .rdata_b (opb)
  );

  // Select a load source
  always_comb begin
    unique case (cmd.src)
      kft_pkg::SRC_ZP:  src_val = inp_r[0];
      kft_pkg::SRC_ZF:  src_val = inp_r[1];
      kft_pkg::SRC_IP:  src_val = inp_r[2];
      kft_pkg::SRC_IF:  src_val = inp_r[3];
      kft_pkg::SRC_VP:  src_val = kft_pkg::DW'(cfg_r[0]);
      kft_pkg::SRC_VF:  src_val = kft_pkg::DW'(cfg_r[1]);
      kft_pkg::SRC_QP:  src_val = kft_pkg::DW'(cfg_r[2]);
      kft_pkg::SRC_QF:  src_val = kft_pkg::DW'(cfg_r[3]);
      kft_pkg::SRC_RP:  src_val = kft_pkg::DW'(cfg_r[4]);
      kft_pkg::SRC_RF:  src_val = kft_pkg::DW'(cfg_r[5]);
      kft_pkg::SRC_ONE: src_val = kft_pkg::Q_ONE;
      default:          src_val = '0;
    endcase
  end

  // Saturating add, subtract, negate, move and load
  always_comb begin
    unique case (cmd.op)
      kft_pkg::OP_LD:  alu_q = src_val;
      kft_pkg::OP_ADD: alu_q = kft_pkg::sat_add(opa, opb);
      kft_pkg::OP_SUB: alu_q = kft_pkg::sat_sub(opa, opb);
      kft_pkg::OP_NEG: alu_q = kft_pkg::sat_sub('0, opa);
      default:         alu_q = opa;
    endcase
  end

  // Multiply, then round the magnitude half away from zero
  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod_r <= $signed(opa) * $signed(opb);
    end
  end

  always_comb begin
    prod_mag = prod_r[2*kft_pkg::DW-1] ? (2*kft_pkg::DW)'(-prod_r) : prod_r;
    prod_rnd = prod_mag + ((2*kft_pkg::DW)'(1) << (kft_pkg::FB - 1));
    mul_q = kft_pkg::sat_mag(prod_rnd[kft_pkg::FB +: kft_pkg::QW], prod_r[2*kft_pkg::DW-1]);
  end

  kft_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go),
    .num   (opa),
    .den   (opb),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  // Write-back select
  always_comb begin
    unique case (cmd.wsel)
      kft_pkg::WS_MUL: wdata = mul_q;
      kft_pkg::WS_DIV: wdata = div_q;
      default:         wdata = alu_q;
    endcase
  end

  // Result buffer
  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      out_r[cmd.cap_idx] <= opa;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_set) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  for (genvar k = 0; k < kft_pkg::NOUT; k++) begin : g_out
    assign out_tdata[k*kft_pkg::DW +: kft_pkg::DW] = out_r[k];
  end

  assign out_tvalid = out_valid_r;
  assign st.a_zero = (opa == '0);
  assign st.div_done = div_done;
  assign st.out_busy = out_valid_r;

  a_cap_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_en |-> !out_valid_r)
    else $error("result buffer written while a result is pending");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_go |-> !div_busy)
    else $error("divider started while busy");

  a_out_set: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_set |=> out_tvalid)
    else $error("result not presented after the buffer was filled");

endmodule
`default_nettype wire

FILE: hw/rtl/kft_ctrl.sv
`default_nettype none
module kft_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic [kft_pkg::KW-1:0] in_kind,
  output logic                       in_tready,
  output kft_pkg::cmd_t              cmd,
  input  wire kft_pkg::stat_t        st
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_MULW  = 3'd3;
  localparam logic [2:0] S_DIVW  = 3'd4;
  localparam logic [2:0] S_COPY  = 3'd5;

  logic [2:0]              state_r, state_nxt;
  logic [kft_pkg::KW-1:0]  kind_r, kind_nxt;
  logic [kft_pkg::SW-1:0]  step_r, step_nxt;
  logic [kft_pkg::CW-1:0]  cnt_r, cnt_nxt;
  logic                    boot_r, boot_nxt;
  logic                    in_acc;
  kft_pkg::uop_t           uop;

  assign uop = kft_pkg::ucode(kind_r, step_r);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;

  // Sequence one micro-op at a time, then, except after the power-on reset program, copy the state to the result buffer
  always_comb begin
    state_nxt = state_r;
    kind_nxt = kind_r;
    step_nxt = step_r;
    cnt_nxt = cnt_r;
    boot_nxt = boot_r;
    cmd = '0;
    cmd.ra = uop.a;
    cmd.rb = uop.b;
    cmd.wa = uop.d;
    cmd.op = uop.op;
    cmd.src = uop.src;
    cmd.wsel = kft_pkg::WS_ALU;
    cmd.cap_idx = cnt_r - 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.in_load = 1'b1;
          kind_nxt = in_kind;
          step_nxt = '0;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        if (uop.op == kft_pkg::OP_END) begin
          cnt_nxt = '0;
          if (boot_r) begin
            boot_nxt = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_COPY;
          end
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (uop.op)
          kft_pkg::OP_BZ: begin
            if (st.a_zero) begin
              cnt_nxt = '0;
              state_nxt = S_COPY;
            end else begin
              step_nxt = step_r + 1'b1;
              state_nxt = S_FETCH;
            end
          end
          kft_pkg::OP_MUL: begin
            cmd.mul_go = 1'b1;
            state_nxt = S_MULW;
          end
          kft_pkg::OP_DIV: begin
            cmd.div_go = 1'b1;
            state_nxt = S_DIVW;
          end
          default: begin
            cmd.we = 1'b1;
            step_nxt = step_r + 1'b1;
            state_nxt = S_FETCH;
          end
        endcase
      end
      S_MULW: begin
        cmd.we = 1'b1;
        cmd.wsel = kft_pkg::WS_MUL;
        step_nxt = step_r + 1'b1;
        state_nxt = S_FETCH;
      end
      S_DIVW: begin
        if (st.div_done) begin
          cmd.we = 1'b1;
          cmd.wsel = kft_pkg::WS_DIV;
          step_nxt = step_r + 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_COPY: begin
        cmd.ra = kft_pkg::AW'(cnt_r);
        // wait for the previous result to drain before the first read
        if (!(cnt_r == '0 && st.out_busy)) begin
          cmd.cap_en = (cnt_r != '0);
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == kft_pkg::CW'(kft_pkg::NOUT)) begin
            cmd.out_set = 1'b1;
            cnt_nxt = '0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // After reset run the reset program once to load the initial state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FETCH;
      kind_r <= kft_pkg::K_RESET;
      step_r <= '0;
      cnt_r <= '0;
      boot_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      kind_r <= kind_nxt;
      step_r <= step_nxt;
      cnt_r <= cnt_nxt;
      boot_r <= boot_nxt;
    end
  end

  a_acc_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_FETCH))
    else $error("accepted request did not start its program");

  a_mul_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && uop.op == kft_pkg::OP_MUL) |=> (state_r == S_MULW))
    else $error("multiply not followed by its write-back");

endmodule
`default_nettype wire
